FILE: rtl/fps_pkg.sv
// Shared types, constants and functions of the single-precision subtractor.
package fps_pkg;

  localparam logic [7:0] ExpMax = 8'hFF;
  localparam logic [4:0] ShiftMax = 5'd31;

  typedef struct packed {
    logic        special;
    logic [31:0] special_y;
    logic        sa;
    logic        sb;
    logic        sbig;
    logic [7:0]  ebig;
    logic [23:0] mbig;
    logic [23:0] msml;
    logic [4:0]  sh;
  } align_t;

  typedef struct packed {
    logic        special;
    logic [31:0] special_y;
    logic        sa;
    logic        sb;
    logic        sbig;
    logic [7:0]  enorm;
    logic [25:0] mnorm;
    logic        sticky;
    logic        ovf1;
  } norm_t;

  typedef struct packed {
    logic        special;
    logic [31:0] special_y;
    logic        sa;
    logic        sb;
    logic        sbig;
    logic [26:0] mfin;
    logic [7:0]  efin;
    logic        sticky;
    logic        ovf1;
  } rnd_t;

  function automatic logic [4:0] lead_zeros26(input logic [25:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd26;
    found = 1'b0;
    for (int i = 25; i >= 0; i--) begin
      if (v[i] && !found) begin
        n = 5'(25 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/fps_unpack.sv
// Stage one: operand decode, special values, operand swap and shift distance.
module fps_unpack import fps_pkg::*; (
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output align_t      align_o
);
  logic [22:0] fa, fb;
  logic [7:0]  ea, eb, xa_e, xb_e, exp_diff;
  logic        sa, sb, nza, nzb, bsel;
  logic [23:0] ma, mb;

  always_comb begin
    fa = operand_a_i[22:0];
    fb = operand_b_i[22:0];
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    sa = operand_a_i[31];
    sb = ~operand_b_i[31];
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    xa_e = (ea != 8'd0) ? ea : 8'd1;
    xb_e = (eb != 8'd0) ? eb : 8'd1;
    nza = (fa != 23'd0);
    nzb = (fb != 23'd0);
    if (xa_e > xb_e) begin
      bsel = 1'b0;
      exp_diff = xa_e - xb_e;
    end else begin
      bsel = 1'b1;
      exp_diff = xb_e - xa_e;
    end
    align_o.sh = (exp_diff > 8'(ShiftMax)) ? ShiftMax : exp_diff[4:0];
    if (align_o.sh == 5'd0) bsel = (ma > mb) ? 1'b0 : 1'b1;
    align_o.mbig = bsel ? mb : ma;
    align_o.msml = bsel ? ma : mb;
    align_o.ebig = bsel ? xb_e : xa_e;
    align_o.sbig = bsel ? sb : sa;
    align_o.sa = sa;
    align_o.sb = sb;
    align_o.special = 1'b1;
    if (ea == ExpMax && eb != ExpMax)
      align_o.special_y = {sa, ExpMax, nza, fa[21:0]};
    else if (eb == ExpMax && ea != ExpMax)
      align_o.special_y = {sb, ExpMax, nzb, fb[21:0]};
    else if (ea == ExpMax && nza)
      align_o.special_y = {sa, ExpMax, 1'b1, fa[21:0]};
    else if (ea == ExpMax && nzb)
      align_o.special_y = {sb, ExpMax, 1'b1, fb[21:0]};
    else if (ea == ExpMax && sa == sb)
      align_o.special_y = {sa, ExpMax, 23'd0};
    else if (ea == ExpMax)
      align_o.special_y = {1'b1, ExpMax, 1'b1, 22'd0};
    else begin
      align_o.special_y = 32'd0;
      align_o.special = 1'b0;
    end
  end
endmodule

FILE: rtl/fps_addsub.sv
// Stage two: alignment shift with sticky, significand add or subtract, carry fix.
module fps_addsub import fps_pkg::*; (
  input  align_t align_i,
  output norm_t  norm_o
);
  logic [54:0] wide;
  logic [26:0] aligned, sum;
  logic [7:0]  ebump;
  logic        sticky;

  always_comb begin
    wide = {align_i.msml, 31'd0} >> align_i.sh;
    sticky = (wide[28:0] != 29'd0);
    aligned = {1'b0, wide[54:29]};
    if (align_i.sa == align_i.sb) sum = {1'b0, align_i.mbig, 2'b00} + aligned;
    else sum = {1'b0, align_i.mbig, 2'b00} - aligned;
    ebump = align_i.ebig + 8'd1;
    norm_o.special = align_i.special;
    norm_o.special_y = align_i.special_y;
    norm_o.sa = align_i.sa;
    norm_o.sb = align_i.sb;
    norm_o.sbig = align_i.sbig;
    norm_o.ovf1 = 1'b0;
    if (sum[26]) begin
      if (ebump == ExpMax) begin
        norm_o.enorm = ExpMax;
        norm_o.mnorm = 26'h2000000;
        norm_o.ovf1 = 1'b1;
        norm_o.sticky = 1'b0;
      end else begin
        norm_o.enorm = ebump;
        norm_o.mnorm = sum[26:1];
        norm_o.sticky = sticky | sum[0];
      end
    end else begin
      norm_o.enorm = align_i.ebig;
      norm_o.mnorm = sum[25:0];
      norm_o.sticky = sticky;
    end
  end
endmodule

FILE: rtl/fps_norm.sv
// Stage three: leading-zero count and normalizing shift.
module fps_norm import fps_pkg::*; (
  input  norm_t norm_i,
  output rnd_t  rnd_o
);
  logic [4:0]  lz, sh;
  logic [9:0]  eshift;

  always_comb begin
    lz = lead_zeros26(norm_i.mnorm);
    eshift = {2'b00, norm_i.enorm} - {5'd0, lz};
    sh = norm_i.enorm[4:0] - 5'd1;
    rnd_o.special = norm_i.special;
    rnd_o.special_y = norm_i.special_y;
    rnd_o.sa = norm_i.sa;
    rnd_o.sb = norm_i.sb;
    rnd_o.sbig = norm_i.sbig;
    rnd_o.sticky = norm_i.sticky;
    rnd_o.ovf1 = norm_i.ovf1;
    if (!eshift[9] && eshift != 10'd0) begin
      rnd_o.mfin = {1'b0, norm_i.mnorm} << lz;
      rnd_o.efin = eshift[7:0];
    end else begin
      rnd_o.mfin = {1'b0, norm_i.mnorm} << sh;
      rnd_o.efin = 8'd0;
    end
  end
endmodule

FILE: rtl/fps_round.sv
// Stage four: round to nearest even, exponent fix-up and result packing.
module fps_round import fps_pkg::*; (
  input  rnd_t        rnd_i,
  output logic [31:0] difference_o,
  output logic        overflow_o
);
  logic        g, r, lsb, up, sy, ovf2;
  logic [24:0] mrnd;
  logic [7:0]  einc, ey;
  logic [22:0] my;

  always_comb begin
    r = rnd_i.mfin[0];
    g = rnd_i.mfin[1];
    lsb = rnd_i.mfin[2];
    up = (g && !r && !rnd_i.sticky && lsb) ||
         (g && !r && rnd_i.sa == rnd_i.sb && rnd_i.sticky) || (g && r);
    mrnd = rnd_i.mfin[26:2] + {24'd0, up};
    einc = rnd_i.efin + 8'd1;
    ovf2 = 1'b0;
    if (mrnd[24]) begin
      ey = einc;
      my = 23'd0;
      ovf2 = (einc == ExpMax);
    end else if (mrnd[23:0] == 24'd0) begin
      ey = 8'd0;
      my = 23'd0;
    end else begin
      ey = (rnd_i.efin == 8'd0 && mrnd[23]) ? 8'd1 : rnd_i.efin;
      my = mrnd[22:0];
    end
    sy = (ey == 8'd0 && my == 23'd0) ? (rnd_i.sa & rnd_i.sb) : rnd_i.sbig;
    if (rnd_i.special) begin
      difference_o = rnd_i.special_y;
      overflow_o = 1'b0;
    end else begin
      difference_o = {sy, ey, my};
      overflow_o = rnd_i.ovf1 | ovf2;
    end
  end
endmodule

FILE: rtl/fp32_subtract.sv
// Top level of the pipelined single-precision subtractor (a minus b).
//   Channel  Handshake          Payload
//   input    in_valid/in_ready  operand_a_i, operand_b_i
//   output   out_valid/out_ready difference_o, overflow_o
// One beat enters per cycle while no stall holds the pipeline.
// The stages are decode, align and add, normalize, round, each registered.
// A stage advances when it is empty or the stage after it moves; a stall holds
// full stages up to a gap and loses nothing. Reset clears the valid bits only.
module fp32_subtract import fps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] difference_o,
  output logic        overflow_o
);
  align_t      align_d, align_q;
  norm_t       norm_d, norm_q;
  rnd_t        rnd_d, rnd_q;
  logic [31:0] diff_d, diff_q;
  logic        ovf_d, ovf_q;
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        en1, en2, en3, en4;

  fps_unpack u_unpack (.operand_a_i, .operand_b_i, .align_o(align_d));
  fps_addsub u_addsub (.align_i(align_q), .norm_o(norm_d));
  fps_norm   u_norm   (.norm_i(norm_q), .rnd_o(rnd_d));
  fps_round  u_round  (.rnd_i(rnd_q), .difference_o(diff_d), .overflow_o(ovf_d));

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) align_q <= align_d;
    if (en2) norm_q <= norm_d;
    if (en3) rnd_q <= rnd_d;
    if (en4) begin
      diff_q <= diff_d;
      ovf_q <= ovf_d;
    end
  end

  assign out_valid_o = v4_q;
  assign difference_o = diff_q;
  assign overflow_o = ovf_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(difference_o))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline blocked with empty output");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> difference_o[30:23] == ExpMax && difference_o[22:0] == 23'd0)
    else $error("overflow without infinity");
endmodule
